// ----- rtl/baro_sensor_compensation_top_assert.svh -----
// Assertion macros for the barometric compensation top level
`ifndef BARO_SENSOR_COMPENSATION_TOP_ASSERT_SVH
`define BARO_SENSOR_COMPENSATION_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define BSC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define BSC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/bsc_pkg.sv -----
// Shared types, widths, register indexes and helpers for barometric compensation
`default_nettype none
package bsc_pkg;

	localparam int unsigned CoefW     = 16;
	localparam int unsigned RawW      = 24;
	localparam int unsigned TempW     = 19;
	localparam int unsigned PresW     = 32;
	localparam int unsigned IdxW      = 3;
	localparam int unsigned DtW       = 25;
	localparam int unsigned ProdW     = 42;
	localparam int unsigned SqW       = 38;
	localparam int unsigned DdW       = 48;
	localparam int unsigned T2W       = 17;
	localparam int unsigned AccW      = 40;
	localparam int unsigned PipeDepth = 10;
	localparam int unsigned CntW      = 4;

	localparam logic [IdxW-1:0] REG_SENS     = 3'd0;
	localparam logic [IdxW-1:0] REG_OFF      = 3'd1;
	localparam logic [IdxW-1:0] REG_SENS_TC  = 3'd2;
	localparam logic [IdxW-1:0] REG_OFF_TC   = 3'd3;
	localparam logic [IdxW-1:0] REG_TREF     = 3'd4;
	localparam logic [IdxW-1:0] REG_TEMPSENS = 3'd5;

	localparam logic signed [TempW-1:0] TEMP_REF  = 19'sd2000;
	localparam logic signed [TempW-1:0] VCOLD_OFS = 19'sd3500;

	typedef struct packed {
		logic [CoefW-1:0] sens;
		logic [CoefW-1:0] off;
		logic [CoefW-1:0] sens_tc;
		logic [CoefW-1:0] off_tc;
		logic [CoefW-1:0] tref;
		logic [CoefW-1:0] tco;
	} cfg_t;

	typedef struct packed {
		logic [RawW-1:0]          d1;
		logic signed [TempW-1:0]  temp;
		logic signed [TempW-1:0]  q;
		logic [T2W-1:0]           t2;
		logic signed [AccW-1:0]   off;
		logic signed [AccW-1:0]   sens;
	} front_t;

	typedef struct packed {
		logic [RawW-1:0]          d1;
		logic signed [TempW-1:0]  tout;
		logic signed [AccW-1:0]   off_c;
		logic signed [AccW-1:0]   sens_c;
	} corr_t;

	// signed divide by 2^k, rounding toward zero
	function automatic logic signed [63:0] sdiv_p2(input logic signed [63:0] x,
		input logic [5:0] k);
		logic signed [63:0] bias;
		bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
		return (x + bias) >>> k;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/bsc_if.sv -----
// Sample and result channel interfaces for barometric compensation
`default_nettype none
interface bsc_samp_if;
	logic                        valid;
	logic                        ready;
	logic [bsc_pkg::RawW-1:0]    raw_pressure;
	logic [bsc_pkg::RawW-1:0]    raw_temperature;

	modport source(output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink(input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bsc_res_if;
	logic                              valid;
	logic                              ready;
	logic signed [bsc_pkg::TempW-1:0]  temperature;
	logic [bsc_pkg::PresW-1:0]         pressure;

	modport source(output valid, output temperature, output pressure, input ready);
	modport sink(input valid, input temperature, input pressure, output ready);
endinterface
`default_nettype wire

// ----- rtl/bsc_cfg.sv -----
// Calibration word registers written through the plain write port
`default_nettype none
module bsc_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       we,
	input  logic [bsc_pkg::IdxW-1:0]   idx,
	input  logic [bsc_pkg::CoefW-1:0]  data,
	output bsc_pkg::cfg_t              cfg
);

	bsc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (we) begin
			case (idx)
				bsc_pkg::REG_SENS:     cfg_q.sens    <= data;
				bsc_pkg::REG_OFF:      cfg_q.off     <= data;
				bsc_pkg::REG_SENS_TC:  cfg_q.sens_tc <= data;
				bsc_pkg::REG_OFF_TC:   cfg_q.off_tc  <= data;
				bsc_pkg::REG_TREF:     cfg_q.tref    <= data;
				bsc_pkg::REG_TEMPSENS: cfg_q.tco     <= data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ----- rtl/bsc_front.sv -----
// First-order stages: dT, coefficient products, TEMP, OFF and SENS
`default_nettype none
module bsc_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [bsc_pkg::RawW-1:0]  d1,
	input  logic [bsc_pkg::RawW-1:0]  d2,
	input  bsc_pkg::cfg_t             cfg,
	output logic                      out_valid,
	output bsc_pkg::front_t           fr
);

	logic                               v_s1, v_s2, v_s3;
	logic [bsc_pkg::RawW-1:0]           d1_s1, d1_s2, d1_s3;
	logic signed [bsc_pkg::DtW-1:0]     dt_s1;
	logic signed [bsc_pkg::ProdW-1:0]   mt_s2, mo_s2, ms_s2;
	logic [bsc_pkg::DdW-1:0]            dd_s2;
	logic signed [2*bsc_pkg::DtW-1:0]   sq;
	logic signed [63:0]                 qw, offw, sensw;
	logic signed [bsc_pkg::TempW-1:0]   q_s3, temp_s3;
	logic [bsc_pkg::T2W-1:0]            t2_s3;
	logic signed [bsc_pkg::AccW-1:0]    off_s3, sens_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign sq = dt_s1 * dt_s1;

	always_comb begin
		qw    = bsc_pkg::sdiv_p2(64'(mt_s2), 6'd23);
		offw  = $signed({32'b0, cfg.off, 16'b0}) + bsc_pkg::sdiv_p2(64'(mo_s2), 6'd7);
		sensw = $signed({33'b0, cfg.sens, 15'b0}) + bsc_pkg::sdiv_p2(64'(ms_s2), 6'd8);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s1   <= d1;
			dt_s1   <= $signed({1'b0, d2}) - $signed({1'b0, cfg.tref, 8'h00});

			d1_s2   <= d1_s1;
			mt_s2   <= dt_s1 * $signed({1'b0, cfg.tco});
			mo_s2   <= dt_s1 * $signed({1'b0, cfg.off_tc});
			ms_s2   <= dt_s1 * $signed({1'b0, cfg.sens_tc});
			dd_s2   <= sq[bsc_pkg::DdW-1:0];

			d1_s3   <= d1_s2;
			q_s3    <= qw[bsc_pkg::TempW-1:0];
			temp_s3 <= qw[bsc_pkg::TempW-1:0] + bsc_pkg::TEMP_REF;
			t2_s3   <= dd_s2[bsc_pkg::DdW-1 -: bsc_pkg::T2W];
			off_s3  <= offw[bsc_pkg::AccW-1:0];
			sens_s3 <= sensw[bsc_pkg::AccW-1:0];
		end
	end

	always_comb begin
		fr.d1   = d1_s3;
		fr.temp = temp_s3;
		fr.q    = q_s3;
		fr.t2   = t2_s3;
		fr.off  = off_s3;
		fr.sens = sens_s3;
	end

	assign out_valid = v_s3;

endmodule
`default_nettype wire

// ----- rtl/bsc_corr.sv -----
// Second-order correction stages: squares, OFF2, SENS2, T2 and corrected terms
`default_nettype none
module bsc_corr (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  bsc_pkg::front_t fr,
	output logic             out_valid,
	output bsc_pkg::corr_t   co
);

	logic                               v_s4, v_s5, v_s6;
	logic signed [bsc_pkg::TempW-1:0]   b;
	logic signed [2*bsc_pkg::TempW-1:0] a2, b2;
	logic [bsc_pkg::SqW-1:0]            a2_s4, b2_s4;
	logic                               cold_s4, vcold_s4;
	logic [bsc_pkg::RawW-1:0]           d1_s4, d1_s5, d1_s6;
	logic signed [bsc_pkg::TempW-1:0]   temp_s4;
	logic [bsc_pkg::T2W-1:0]            t2_s4;
	logic signed [bsc_pkg::AccW-1:0]    off_s4, sens_s4, off_s5, sens_s5;
	logic [bsc_pkg::SqW-1:0]            a5, b7, b11, off2, sens2;
	logic [bsc_pkg::SqW-1:0]            off2_s5, sens2_s5;
	logic signed [bsc_pkg::TempW-1:0]   tout_s5, tout_s6;
	logic signed [bsc_pkg::AccW-1:0]    off_c_s6, sens_c_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s4 <= in_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_comb begin
		b  = fr.q + bsc_pkg::VCOLD_OFS;
		a2 = fr.q * fr.q;
		b2 = b * b;
	end

	always_comb begin
		a5    = a2_s4 + (a2_s4 << 2);
		b7    = (b2_s4 << 3) - b2_s4;
		b11   = (b2_s4 << 3) + (b2_s4 << 1) + b2_s4;
		off2  = (a5 >> 1) + (vcold_s4 ? b7 : '0);
		sens2 = (a5 >> 2) + (vcold_s4 ? (b11 >> 1) : '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s4    <= fr.d1;
			temp_s4  <= fr.temp;
			t2_s4    <= fr.t2;
			off_s4   <= fr.off;
			sens_s4  <= fr.sens;
			cold_s4  <= fr.q[bsc_pkg::TempW-1];
			vcold_s4 <= b[bsc_pkg::TempW-1];
			a2_s4    <= a2[bsc_pkg::SqW-1:0];
			b2_s4    <= b2[bsc_pkg::SqW-1:0];

			d1_s5    <= d1_s4;
			off_s5   <= off_s4;
			sens_s5  <= sens_s4;
			off2_s5  <= cold_s4 ? off2 : '0;
			sens2_s5 <= cold_s4 ? sens2 : '0;
			tout_s5  <= temp_s4 - (cold_s4 ? $signed({2'b0, t2_s4}) : '0);

			d1_s6     <= d1_s5;
			tout_s6   <= tout_s5;
			off_c_s6  <= off_s5 - $signed({2'b0, off2_s5});
			sens_c_s6 <= sens_s5 - $signed({2'b0, sens2_s5});
		end
	end

	always_comb begin
		co.d1     = d1_s6;
		co.tout   = tout_s6;
		co.off_c  = off_c_s6;
		co.sens_c = sens_c_s6;
	end

	assign out_valid = v_s6;

endmodule
`default_nettype wire

// ----- rtl/bsc_pres.sv -----
// Pressure stages: split D1*SENS product, scaling, offset and output register
`default_nettype none
module bsc_pres (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  bsc_pkg::corr_t                   co,
	output logic                             out_valid,
	output logic signed [bsc_pkg::TempW-1:0] temperature,
	output logic [bsc_pkg::PresW-1:0]        pressure
);

	localparam int unsigned LoW = 20;
	localparam int unsigned HiW = bsc_pkg::AccW - LoW;
	localparam int unsigned PlW = bsc_pkg::RawW + LoW;
	localparam int unsigned PhW = bsc_pkg::RawW + 1 + HiW;
	localparam int unsigned XW  = 45;

	logic                             v_s7, v_s8, v_s9, v_s10;
	logic [PlW-1:0]                   pl_s7;
	logic signed [PhW-1:0]            ph_s7;
	logic signed [bsc_pkg::AccW-1:0]  off_s7, off_s8;
	logic signed [bsc_pkg::TempW-1:0] tout_s7, tout_s8, tout_s9, tout_s10;
	logic signed [63:0]               prod, prod_s8, xw, pw;
	logic signed [XW-1:0]             x_s9;
	logic [bsc_pkg::PresW-1:0]        p_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s7  <= in_valid;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_comb begin
		prod = (64'(ph_s7) <<< LoW) + $signed({(64 - PlW)'(0), pl_s7});
		xw   = bsc_pkg::sdiv_p2(prod_s8, 6'd21) - 64'(off_s8);
		pw   = bsc_pkg::sdiv_p2(64'(x_s9), 6'd15);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s7    <= co.d1 * co.sens_c[LoW-1:0];
			ph_s7    <= $signed({1'b0, co.d1}) * $signed(co.sens_c[bsc_pkg::AccW-1:LoW]);
			off_s7   <= co.off_c;
			tout_s7  <= co.tout;

			prod_s8  <= prod;
			off_s8   <= off_s7;
			tout_s8  <= tout_s7;

			x_s9     <= xw[XW-1:0];
			tout_s9  <= tout_s8;

			p_s10    <= pw[bsc_pkg::PresW-1:0];
			tout_s10 <= tout_s9;
		end
	end

	assign out_valid   = v_s10;
	assign temperature = tout_s10;
	assign pressure    = p_s10;

endmodule
`default_nettype wire

// ----- rtl/baro_sensor_compensation_top.sv -----
// Top level of the barometric sensor second-order compensation pipeline
// Takes one raw pressure/temperature request per cycle and returns the
// compensated temperature (0.01 degree) and pressure (Pa) through the ten
// register stages of the multiplier chain (dT, coefficient products,
// first-order terms, squares, corrections, corrected terms, split D1*SENS
// product, recombine, offset, output).
// When the result is not taken the whole pipeline holds and no new request
// is accepted. Calibration words are written through cfg_we/cfg_idx/cfg_data
// and must only change while no request is in flight.
`default_nettype none
module baro_sensor_compensation_top (
	input  logic                       clk,
	input  logic                       arst_n,
	bsc_samp_if.sink                   samp,
	bsc_res_if.source                  res,
	input  logic                       cfg_we,
	input  logic [bsc_pkg::IdxW-1:0]   cfg_idx,
	input  logic [bsc_pkg::CoefW-1:0]  cfg_data
);

	bsc_pkg::cfg_t              cfg;
	bsc_pkg::front_t            fr;
	bsc_pkg::corr_t             co;
	logic                       en;
	logic                       fr_valid, co_valid;
	logic                       in_acc, out_acc;
	logic [bsc_pkg::CntW-1:0]   cnt_q;
	logic                       out_wait, one_left, over_cap;

	assign en         = !res.valid || res.ready;
	assign samp.ready = en;
	assign in_acc     = samp.valid && samp.ready;
	assign out_acc    = res.valid && res.ready;

	bsc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_idx),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	bsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (samp.valid),
		.d1        (samp.raw_pressure),
		.d2        (samp.raw_temperature),
		.cfg       (cfg),
		.out_valid (fr_valid),
		.fr        (fr)
	);

	bsc_corr u_corr (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.fr        (fr),
		.out_valid (co_valid),
		.co        (co)
	);

	bsc_pres u_pres (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (co_valid),
		.co          (co),
		.out_valid   (res.valid),
		.temperature (res.temperature),
		.pressure    (res.pressure)
	);

	// requests in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   cnt_q <= cnt_q + bsc_pkg::CntW'(1);
				2'b01:   cnt_q <= cnt_q - bsc_pkg::CntW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign out_wait = res.valid && !res.ready;
	assign one_left = cnt_q == bsc_pkg::CntW'(1);
	assign over_cap = cnt_q > bsc_pkg::CntW'(bsc_pkg::PipeDepth);

`include "baro_sensor_compensation_top_assert.svh"

	`BSC_ASSERT_IMP(a_stall_blocks_input, out_wait, !samp.ready, "request taken during stall")
	`BSC_ASSERT_IMP(a_no_phantom_result, res.valid, cnt_q != '0, "result with none in flight")
	`BSC_ASSERT_IMP(a_occupancy_bound, 1'b1, !over_cap, "more requests in flight than stages")
	`BSC_ASSERT_NXT(a_drain_last, out_acc && !in_acc && one_left, !res.valid, "result after drain")

endmodule
`default_nettype wire

// ----- sim/tb_baro_sensor_compensation_top.sv -----
// Testbench for baro_sensor_compensation_top: directed vectors, random samples, predictor check
`timescale 1ns / 1ps
module tb_baro_sensor_compensation_top;

	localparam int     ClkPeriod = 8;
	localparam int     ResetCycles = 7;
	localparam int     LimitNs = 2_000_000;
	localparam int     BlockItems = 95;
	localparam int     LongHold = 300;
	localparam int     BurstItems = 40;
	localparam longint TempRef = 2000;
	localparam longint VeryCold = -1500;
	localparam longint ScaleTemp = 8388608;
	localparam longint ScaleOff = 65536;
	localparam longint ScaleOffTc = 128;
	localparam longint ScaleSens = 32768;
	localparam longint ScaleSensTc = 256;
	localparam longint ScaleT2 = 64'sd2147483648;
	localparam longint ScaleLoad = 2097152;
	localparam longint ScalePres = 32768;
	localparam logic [bsc_pkg::RawW-1:0] RawMax = '1;

	typedef enum logic [1:0] {CAL_CLEAR, CAL_TYPICAL, CAL_MAX, CAL_HOT} cal_id_t;

	typedef struct packed {
		logic signed [bsc_pkg::TempW-1:0] temperature;
		logic [bsc_pkg::PresW-1:0]        pressure;
	} reading_t;

	typedef struct packed {
		cal_id_t                  cal;
		logic [bsc_pkg::RawW-1:0] d1;
		logic [bsc_pkg::RawW-1:0] d2;
		logic                     typed;
		reading_t                 want;
	} vector_t;

	localparam reading_t NoReading = '0;
	localparam reading_t AfterReset = '{19'sd2000, 32'd0};

	localparam vector_t Directed [20] = '{
		'{CAL_CLEAR,   24'd0,       24'd0,       1'b1, AfterReset},
		'{CAL_CLEAR,   RawMax,      RawMax,      1'b1, AfterReset},
		'{CAL_CLEAR,   24'hAAAAAA,  24'h555555,  1'b1, AfterReset},
		'{CAL_CLEAR,   24'h555555,  24'hAAAAAA,  1'b1, AfterReset},
		'{CAL_TYPICAL, 24'd9085466, 24'd8569150, 1'b0, NoReading},
		'{CAL_TYPICAL, 24'd9085466, 24'd8566784, 1'b0, NoReading},
		'{CAL_TYPICAL, 24'd9085466, 24'd8566488, 1'b0, NoReading},
		'{CAL_TYPICAL, 24'd9085466, 24'd8566487, 1'b0, NoReading},
		'{CAL_TYPICAL, 24'd9085466, 24'd7529468, 1'b0, NoReading},
		'{CAL_TYPICAL, 24'd9085466, 24'd7529467, 1'b0, NoReading},
		'{CAL_TYPICAL, 24'd0,       24'd0,       1'b0, NoReading},
		'{CAL_TYPICAL, RawMax,      24'd0,       1'b0, NoReading},
		'{CAL_TYPICAL, RawMax,      RawMax,      1'b0, NoReading},
		'{CAL_TYPICAL, 24'd0,       RawMax,      1'b0, NoReading},
		'{CAL_MAX,     RawMax,      24'd0,       1'b0, NoReading},
		'{CAL_MAX,     24'd0,       RawMax,      1'b0, NoReading},
		'{CAL_MAX,     RawMax,      RawMax,      1'b0, NoReading},
		'{CAL_HOT,     RawMax,      RawMax,      1'b0, NoReading},
		'{CAL_HOT,     24'd0,       24'd0,       1'b0, NoReading},
		'{CAL_CLEAR,   RawMax,      24'd0,       1'b1, AfterReset}
	};

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	logic [bsc_pkg::IdxW-1:0]   cfg_idx;
	logic [bsc_pkg::CoefW-1:0]  cfg_data;

	bsc_samp_if samp ();
	bsc_res_if  res ();

	bsc_pkg::cfg_t cal;
	cal_id_t       cur_cal;
	reading_t      readings_due [$];
	int            mismatches = 0;
	int unsigned   tx_idle_pct = 30;
	int unsigned   rx_idle_pct = 63;
	logic          hold_on = 1'b0;

	baro_sensor_compensation_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samp     (samp),
		.res      (res),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always #(ClkPeriod / 2) clk = ~clk;

	function automatic reading_t compensate(input bsc_pkg::cfg_t c,
		input logic [bsc_pkg::RawW-1:0] d1_raw, input logic [bsc_pkg::RawW-1:0] d2_raw);
		longint d1, dt, temp, off, sens, t2, off2, sens2, cold, vcold, p, tout;
		reading_t r;
		d1 = longint'(d1_raw);
		dt = longint'(d2_raw) - longint'(c.tref) * 256;
		temp = TempRef + dt * longint'(c.tco) / ScaleTemp;
		off = longint'(c.off) * ScaleOff + longint'(c.off_tc) * dt / ScaleOffTc;
		sens = longint'(c.sens) * ScaleSens + longint'(c.sens_tc) * dt / ScaleSensTc;
		t2 = 0;
		off2 = 0;
		sens2 = 0;
		if (temp < TempRef) begin
			cold = (temp - TempRef) * (temp - TempRef);
			t2 = dt * dt / ScaleT2;
			off2 = 5 * cold / 2;
			sens2 = 5 * cold / 4;
			if (temp < VeryCold) begin
				vcold = (temp - VeryCold) * (temp - VeryCold);
				off2 += 7 * vcold;
				sens2 += 11 * vcold / 2;
			end
		end
		p = (d1 * (sens - sens2) / ScaleLoad - (off - off2)) / ScalePres;
		tout = temp - t2;
		r.temperature = tout[bsc_pkg::TempW-1:0];
		r.pressure = p[bsc_pkg::PresW-1:0];
		return r;
	endfunction

	function automatic bsc_pkg::cfg_t cal_words(input cal_id_t id);
		case (id)
			CAL_TYPICAL: return '{16'd40127, 16'd36924, 16'd23317,
				16'd23282, 16'd33464, 16'd28312};
			CAL_MAX:     return '1;
			CAL_HOT:     return '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF};
			default:     return '0;
		endcase
	endfunction

	function automatic bsc_pkg::cfg_t random_calibration();
		logic [bsc_pkg::CoefW-1:0] w [6];
		for (int i = 0; i < 6; i++) begin
			case ($urandom_range(7))
				0:       w[i] = '0;
				1:       w[i] = '1;
				default: w[i] = bsc_pkg::CoefW'($urandom);
			endcase
		end
		return '{w[0], w[1], w[2], w[3], w[4], w[5]};
	endfunction

	task automatic wait_drained();
		while (readings_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_calibration(input bsc_pkg::cfg_t c);
		logic [bsc_pkg::IdxW-1:0] idx;
		samp.valid <= 1'b0;
		wait_drained();
		@(posedge clk);
		for (int i = 0; i < (1 << bsc_pkg::IdxW); i++) begin
			idx = bsc_pkg::IdxW'(i);
			cfg_we <= 1'b1;
			cfg_idx <= idx;
			case (idx)
				bsc_pkg::REG_SENS:     cfg_data <= c.sens;
				bsc_pkg::REG_OFF:      cfg_data <= c.off;
				bsc_pkg::REG_SENS_TC:  cfg_data <= c.sens_tc;
				bsc_pkg::REG_OFF_TC:   cfg_data <= c.off_tc;
				bsc_pkg::REG_TREF:     cfg_data <= c.tref;
				bsc_pkg::REG_TEMPSENS: cfg_data <= c.tco;
				default:               cfg_data <= bsc_pkg::CoefW'($urandom);
			endcase
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cal = c;
	endtask

	task automatic offer_sample(input logic [bsc_pkg::RawW-1:0] d1,
		input logic [bsc_pkg::RawW-1:0] d2, input logic typed, input reading_t want);
		while ($urandom_range(99) < tx_idle_pct) begin
			samp.valid <= 1'b0;
			samp.raw_pressure <= bsc_pkg::RawW'($urandom);
			samp.raw_temperature <= bsc_pkg::RawW'($urandom);
			@(posedge clk);
		end
		samp.valid <= 1'b1;
		samp.raw_pressure <= d1;
		samp.raw_temperature <= d2;
		do
			@(posedge clk);
		while (!samp.ready);
		readings_due.push_back(typed ? want : compensate(cal, d1, d2));
	endtask

	task automatic offer_random();
		logic [bsc_pkg::RawW-1:0] d1, d2;
		int base, spread, v;
		case ($urandom_range(4))
			0:       d1 = $urandom_range(1) ? RawMax : '0;
			default: d1 = bsc_pkg::RawW'($urandom);
		endcase
		base = int'(cal.tref) * 256;
		spread = 1 << $urandom_range(23, 6);
		case ($urandom_range(9))
			0, 1, 2: d2 = bsc_pkg::RawW'($urandom);
			3:       d2 = $urandom_range(1) ? RawMax : '0;
			default: begin
				v = base + int'($urandom_range(2 * spread)) - spread;
				if (v < 0)
					v = 0;
				if (v > int'(RawMax))
					v = int'(RawMax);
				d2 = bsc_pkg::RawW'(v);
			end
		endcase
		offer_sample(d1, d2, 1'b0, NoReading);
	endtask

	// receiver: random backpressure, long hold-off on request
	initial begin
		int hold_count;
		hold_count = 0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_on && hold_count < LongHold) begin
				res.ready <= 1'b0;
				hold_count++;
			end else begin
				if (!hold_on)
					hold_count = 0;
				res.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && res.valid && res.ready) begin
			if (readings_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result temperature %0d pressure %0d",
					$time, res.temperature, res.pressure);
			end else begin
				want = readings_due.pop_front();
				if (res.temperature !== want.temperature) begin
					mismatches++;
					$display("%0t: temperature expected %0d actual %0d",
						$time, want.temperature, res.temperature);
				end
				if (res.pressure !== want.pressure) begin
					mismatches++;
					$display("%0t: pressure expected %0d actual %0d",
						$time, want.pressure, res.pressure);
				end
			end
		end
	end

	initial begin
		#(LimitNs);
		$display("** baro_sensor_compensation_top: FAILED **");
		$finish;
	end

	initial begin
		bsc_pkg::cfg_t c;
		arst_n <= 1'b0;
		samp.valid <= 1'b0;
		samp.raw_pressure <= '0;
		samp.raw_temperature <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= bsc_pkg::REG_SENS;
		cfg_data <= '0;
		cal = '0;
		cur_cal = CAL_CLEAR;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(Directed); i++) begin
			if (Directed[i].cal != cur_cal || i == $size(Directed) - 1) begin
				cur_cal = Directed[i].cal;
				load_calibration(cal_words(cur_cal));
			end
			offer_sample(Directed[i].d1, Directed[i].d2, Directed[i].typed, Directed[i].want);
		end

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 63 : 0;
			rx_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 30 : 0;
			for (int blk = 0; blk < 3; blk++) begin
				if (blk < 2)
					c = random_calibration();
				else
					c = cal_words((ph == 0) ? CAL_MAX : (ph == 1) ? CAL_CLEAR : CAL_HOT);
				load_calibration(c);
				repeat (BlockItems) offer_random();
			end
		end

		// fill the pipeline against a stalled receiver, then drain before resuming
		load_calibration(cal_words(CAL_TYPICAL));
		hold_on <= 1'b1;
		repeat (BurstItems) offer_random();
		hold_on <= 1'b0;
		samp.valid <= 1'b0;
		wait_drained();
		tx_idle_pct = 30;
		rx_idle_pct = 30;
		repeat (BurstItems / 2) offer_random();

		samp.valid <= 1'b0;
		wait_drained();
		repeat (2 * bsc_pkg::PipeDepth) @(posedge clk);
		if (mismatches == 0)
			$display("** baro_sensor_compensation_top: PASSED **");
		else
			$display("** baro_sensor_compensation_top: FAILED **");
		$finish;
	end

endmodule
